/* design/lkv_pkg.sv */
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants for the LRU key-value cache
// Entry layout, cell control group, operation codes and register widths.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // operation codes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    // one cache entry as held by a cell
    typedef struct packed {
        logic                     valid;
        logic signed [KEY_W-1:0]  key;
        logic signed [DATA_W-1:0] data;
    } t_entry;

    // control broadcast to every cell
    typedef struct packed {
        logic cmp_en;   // register the key compare
        logic upd_en;   // shift entries up to the limit position
    } t_cell_ctl;

endpackage

/* design/lkv_if.sv */
// ----------------------------------------------------------------------------
// lkv_req_if / lkv_rsp_if: request and response channels
// Valid/ready handshake; an item moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface lkv_req_if;
    logic                             valid;
    logic                             ready;
    logic                             operation;
    logic signed [lkv_pkg::KEY_W-1:0]  key;
    logic signed [lkv_pkg::DATA_W-1:0] value;

    modport source (output valid, operation, key, value, input ready);
    modport sink   (input valid, operation, key, value, output ready);
endinterface

interface lkv_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             hit;
    logic signed [lkv_pkg::DATA_W-1:0] read_value;
    logic                             evicted;
    logic signed [lkv_pkg::KEY_W-1:0]  evicted_key;

    modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
    modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

/* design/lkv_cell.sv */
// ----------------------------------------------------------------------------
// lkv_cell: one recency position of the cache
// Holds one entry, compares it to the request key, and takes its neighbour's
// entry when the chain shifts through its position.
// ----------------------------------------------------------------------------
module lkv_cell #(
    parameter int ENTRIES = 16,
    parameter int INDEX   = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lkv_pkg::t_cell_ctl                i_ctl,
    input  logic signed [lkv_pkg::KEY_W-1:0]  i_key,
    input  logic [$clog2(ENTRIES+1)-1:0]      i_limit,
    input  lkv_pkg::t_entry                   i_prev,
    output lkv_pkg::t_entry                   o_entry,
    output logic                              o_match
);

    localparam int LW = $clog2(ENTRIES + 1);
    localparam logic [LW-1:0] POS = LW'(INDEX);

    logic            r_valid;
    lkv_pkg::t_entry r_entry;
    logic            r_match;
    logic            w_shift;

    assign w_shift = i_ctl.upd_en && (POS <= i_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.cmp_en) begin
                r_match <= r_valid && (r_entry.key == i_key);
            end
            if (w_shift) begin
                r_valid <= i_prev.valid;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_entry <= i_prev;
        end
    end

    always_comb begin
        o_entry       = r_entry;
        o_entry.valid = r_valid;
    end

    assign o_match = r_match;

endmodule

/* design/lru_key_value_cache_top.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache_top: fully associative key-value cache, LRU replacement
// A row of cells ordered by recency, position 0 most recent.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------
//  i_req    | in  | valid / ready      | operation, key, value
//  o_rsp    | out | valid / ready      | hit, read_value, evicted, evicted_key
//  i_cfg    | in  | i_cfg_we only      | i_cfg_wdata = capacity
//
//  An item passes through a compare state, which checks the key in every cell
//  in parallel, and an update state, which locates the match, shifts the cell
//  chain and registers the result. A new item can be taken in the update state
//  of the previous one, when that item commits while o_rsp drains.
//  Reset (synchronous, active low) empties every cell and sets capacity 16.
//  A stalled response holds the update cycle; the cells do not move until
//  the result register is free.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top #(
    parameter int ENTRIES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    lkv_req_if.sink                         i_req,
    lkv_rsp_if.source                       o_rsp,
    input  logic                            i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]       i_cfg_wdata
);

    localparam int LW = $clog2(ENTRIES + 1);
    localparam int FW = (LW > lkv_pkg::CAP_W) ? LW : lkv_pkg::CAP_W;
    localparam logic [FW-1:0] ENT_X = FW'(ENTRIES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    // control
    logic [1:0]                   r_state, n_state;
    logic [LW-1:0]                r_fill, n_fill;
    logic [lkv_pkg::CAP_W-1:0]    r_cap;
    logic                         r_out_valid;

    // latched request
    logic                               r_op;
    logic signed [lkv_pkg::KEY_W-1:0]   r_key;
    logic signed [lkv_pkg::DATA_W-1:0]  r_val;

    // result register
    logic                               r_hit;
    logic signed [lkv_pkg::DATA_W-1:0]  r_rd;
    logic                               r_ev;
    logic signed [lkv_pkg::KEY_W-1:0]   r_evk;

    logic                   w_accept, w_commit, w_free;
    lkv_pkg::t_cell_ctl     w_ctl;
    lkv_pkg::t_entry        w_entry [ENTRIES];
    lkv_pkg::t_entry        w_head;
    logic [ENTRIES-1:0]     w_match;
    logic                   w_hit, w_full, w_evict;
    logic [LW-1:0]          w_pos, w_limit;
    logic signed [lkv_pkg::DATA_W-1:0] w_hit_data;
    logic signed [lkv_pkg::KEY_W-1:0]  w_last_key;
    logic [FW-1:0]          w_fill_x, w_cap_x;

    // handshake: take a new item when idle or while the current one commits
    assign w_free     = !r_out_valid || o_rsp.ready;
    assign w_commit   = (r_state == ST_UPD) && w_free;
    assign i_req.ready = (r_state == ST_IDLE) || w_commit;
    assign w_accept   = i_req.valid && i_req.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_CMP;
            ST_CMP:  n_state = ST_UPD;
            ST_UPD: begin
                if (w_accept) begin
                    n_state = ST_CMP;
                end else if (w_commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // match location and the entries it selects; at most one cell matches
    always_comb begin
        w_pos      = '0;
        w_hit_data = '0;
        w_last_key = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_match[i]) begin
                w_pos      = w_pos | LW'(i);
                w_hit_data = w_hit_data | w_entry[i].data;
            end
            // last valid cell is the least recent entry; valid cells are a prefix
            if (w_entry[i].valid && ((i == ENTRIES - 1) || !w_entry[(i + 1) % ENTRIES].valid)) begin
                w_last_key = w_last_key | w_entry[i].key;
            end
        end
    end

    assign w_hit = |w_match;

    // full when fill reaches the effective capacity (0 acts as 1, clip at ENTRIES)
    assign w_fill_x = FW'(r_fill);
    assign w_cap_x  = FW'(r_cap);
    assign w_full   = (w_fill_x >= ENT_X)
                   || ((r_cap != '0) && (w_fill_x >= w_cap_x))
                   || ((r_cap == '0) && (r_fill != '0));
    assign w_evict  = (r_op == lkv_pkg::OP_SET) && !w_hit && w_full && (r_fill != '0);

    // shift limit: hit moves the matched entry to the head; insert shifts
    // over the filled cells, dropping the last one when full
    always_comb begin
        priority if (w_hit) begin
            w_limit = w_pos;
        end else if (w_evict) begin
            w_limit = r_fill - LW'(1);
        end else begin
            w_limit = r_fill;
        end
    end

    assign w_ctl.cmp_en = (r_state == ST_CMP);
    assign w_ctl.upd_en = w_commit && (w_hit || (r_op == lkv_pkg::OP_SET));

    // new head entry: the request key with written or kept data
    always_comb begin
        w_head.valid = 1'b1;
        w_head.key   = r_key;
        w_head.data  = (r_op == lkv_pkg::OP_SET) ? r_val : w_hit_data;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lkv_cell #(
            .ENTRIES (ENTRIES),
            .INDEX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_key   (r_key),
            .i_limit (w_limit),
            .i_prev  ((g == 0) ? w_head : w_entry[(g + ENTRIES - 1) % ENTRIES]),
            .o_entry (w_entry[g]),
            .o_match (w_match[g])
        );
    end

    always_comb begin
        n_fill = r_fill;
        if (w_commit && (r_op == lkv_pkg::OP_SET) && !w_hit && !w_evict) begin
            n_fill = r_fill + LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_cap       <= lkv_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: hold the request, capture the result on commit
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_req.operation;
            r_key <= i_req.key;
            r_val <= i_req.value;
        end
        if (w_commit) begin
            r_hit <= w_hit;
            r_rd  <= (w_hit && (r_op == lkv_pkg::OP_GET)) ? w_hit_data : '0;
            r_ev  <= w_evict;
            r_evk <= w_evict ? w_last_key : '0;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_hit;
    assign o_rsp.read_value  = r_rd;
    assign o_rsp.evicted     = r_ev;
    assign o_rsp.evicted_key = r_evk;

endmodule

/* dv/lru_key_value_cache_top_tb.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache_top_tb: self-checking bench for the LRU key-value cache
// Drives get/set requests with random gaps and response stalls, predicts
// each response from a shadow copy of the store and its recency order,
// and compares every field of every response in arrival order.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES       = 16;
    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 12;
    localparam int MAX_IDLE      = 10;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_COUNT   = 10;
    localparam int PHASE_ITEMS   = 125;
    localparam int LONG_HOLD_PHASE = 2;
    localparam int DRAIN_PHASE   = 5;
    localparam int DIRECTED_ROWS = 24;

    // capacity per random phase: reset value, lowered below the fill,
    // the extremes 0 and 31 which clamp to 1 and ENTRIES
    localparam logic [lkv_pkg::CAP_W-1:0] PHASE_CAPACITY [PHASE_COUNT] =
        '{5'd16, 5'd3, 5'd1, 5'd31, 5'd0, 5'd8, 5'd2, 5'd16, 5'd5, 5'd12};

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic        evicted;
        logic [31:0] evicted_key;
    } t_result;

    typedef enum logic {ROW_ITEM, ROW_CAPACITY} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic        operation;
        logic [31:0] key;
        logic [31:0] value;      // capacity in bits 4:0 for a register row
        logic        typed;      // expected result written into the row
        t_result     expected;
    } t_stim_row;

    // ------------------------------------------------------------------------
    // Directed table. Typed rows carry results that are plain from the rules
    // (misses on an empty store, hits on extreme keys and values, update of
    // a present key); the rest are left to the predictor.
    // ------------------------------------------------------------------------
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        // get on the empty store
        '{ROW_ITEM, lkv_pkg::OP_GET, 32'h0000_0000, 32'h1234_5678, 1'b1,
          '{1'b0, 32'h0, 1'b0, 32'h0}},
        // extreme keys and values
        '{ROW_ITEM, lkv_pkg::OP_SET, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
          '{1'b0, 32'h0, 1'b0, 32'h0}},
        '{ROW_ITEM, lkv_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1,
          '{1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0}},
        '{ROW_ITEM, lkv_pkg::OP_SET, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
          '{1'b0, 32'h0, 1'b0, 32'h0}},
        '{ROW_ITEM, lkv_pkg::OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{1'b1, 32'h8000_0000, 1'b0, 32'h0}},
        // set on a present key: update, hit, no eviction
        '{ROW_ITEM, lkv_pkg::OP_SET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{1'b1, 32'h0, 1'b0, 32'h0}},
        '{ROW_ITEM, lkv_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1,
          '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
        '{ROW_ITEM, lkv_pkg::OP_SET, 32'h0000_0000, 32'h0000_0000, 1'b1,
          '{1'b0, 32'h0, 1'b0, 32'h0}},
        '{ROW_ITEM, lkv_pkg::OP_SET, 32'hFFFF_FFFF, 32'h5555_5555, 1'b1,
          '{1'b0, 32'h0, 1'b0, 32'h0}},
        '{ROW_ITEM, lkv_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
          '{1'b1, 32'h5555_5555, 1'b0, 32'h0}},
        // get miss leaves the store alone
        '{ROW_ITEM, lkv_pkg::OP_GET, 32'h0000_3039, 32'h0000_0000, 1'b1,
          '{1'b0, 32'h0, 1'b0, 32'h0}},
        '{ROW_ITEM, lkv_pkg::OP_SET, 32'h0000_0000, 32'hAAAA_AAAA, 1'b1,
          '{1'b1, 32'h0, 1'b0, 32'h0}},
        // capacity 0 acts as 1: the store holds four, the oldest goes first
        '{ROW_CAPACITY, lkv_pkg::OP_GET, 32'h0, 32'd0, 1'b0, '0},
        '{ROW_ITEM, lkv_pkg::OP_SET, 32'h0000_0007, 32'h1234_5678, 1'b1,
          '{1'b0, 32'h0, 1'b1, 32'h8000_0000}},
        '{ROW_ITEM, lkv_pkg::OP_SET, 32'h0000_0008, 32'hDEAD_BEEF, 1'b0, '0},
        '{ROW_ITEM, lkv_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '0},
        '{ROW_ITEM, lkv_pkg::OP_SET, 32'h0000_0000, 32'h0F0F_0F0F, 1'b0, '0},
        // capacity above ENTRIES clamps: no eviction while room remains
        '{ROW_CAPACITY, lkv_pkg::OP_GET, 32'h0, 32'd31, 1'b0, '0},
        '{ROW_ITEM, lkv_pkg::OP_SET, 32'h0000_0009, 32'hF0F0_F0F0, 1'b0, '0},
        '{ROW_ITEM, lkv_pkg::OP_GET, 32'h0000_0007, 32'h0000_0000, 1'b0, '0},
        // capacity lowered below the fill
        '{ROW_CAPACITY, lkv_pkg::OP_GET, 32'h0, 32'd2, 1'b0, '0},
        '{ROW_ITEM, lkv_pkg::OP_SET, 32'h0000_000A, 32'h0000_0001, 1'b0, '0},
        '{ROW_ITEM, lkv_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, '0},
        '{ROW_CAPACITY, lkv_pkg::OP_GET, 32'h0, 32'd16, 1'b0, '0}
    };

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [lkv_pkg::CAP_W-1:0] cfg_wdata = lkv_pkg::CAP_RESET;

    lkv_req_if req_if ();
    lkv_rsp_if rsp_if ();

    lru_key_value_cache_top #(
        .ENTRIES     (ENTRIES)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow store: slot contents, recency rank (0 = most recent), fill and
    // the capacity register as last written.
    // ------------------------------------------------------------------------
    logic                      held_valid [ENTRIES];
    logic [31:0]               held_key   [ENTRIES];
    logic [31:0]               held_data  [ENTRIES];
    int unsigned               held_rank  [ENTRIES];
    int unsigned               held_fill;
    logic [lkv_pkg::CAP_W-1:0] held_capacity;

    t_result expected_results [$];

    bit idle_enable     = 1'b1;
    bit rx_hold_request = 1'b0;
    int mismatch_count  = 0;
    int cycle_count     = 0;

    // Clamp the register: 0 acts as 1, anything above ENTRIES as ENTRIES.
    function automatic int unsigned capacity_limit(input logic [lkv_pkg::CAP_W-1:0] cap);
        int unsigned c;
        c = 32'(cap);
        if (c == 0) c = 1;
        if (c > ENTRIES) c = ENTRIES;
        return c;
    endfunction

    // Apply one request to the shadow store and return the response it owes.
    task automatic predict_access(input logic op, input logic [31:0] key,
                                  input logic [31:0] value, output t_result res);
        int          found;
        int          victim;
        int          slot;
        int unsigned rank_was;
        res   = '0;
        found = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (found < 0 && held_valid[i] && held_key[i] == key) found = i;
        end

        if (found >= 0) begin
            res.hit = 1'b1;
            if (op == lkv_pkg::OP_GET) res.read_value = held_data[found];
            else held_data[found] = value;
            // move to the front; everything more recent ages by one
            rank_was = held_rank[found];
            for (int i = 0; i < ENTRIES; i++) begin
                if (held_valid[i] && held_rank[i] < rank_was) held_rank[i]++;
            end
            held_rank[found] = 0;
        end else if (op == lkv_pkg::OP_SET) begin
            slot = 0;
            if (held_fill >= capacity_limit(held_capacity)) begin
                // drop the least recent entry
                victim = -1;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (held_valid[i] && (victim < 0 || held_rank[i] > held_rank[victim]))
                        victim = i;
                end
                if (victim >= 0) begin
                    res.evicted     = 1'b1;
                    res.evicted_key = held_key[victim];
                    held_valid[victim] = 1'b0;
                    held_fill--;
                    slot = victim;
                end
            end else begin
                slot = -1;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot < 0 && !held_valid[i]) slot = i;
                end
            end
            for (int i = 0; i < ENTRIES; i++) begin
                if (held_valid[i]) held_rank[i]++;
            end
            held_valid[slot] = 1'b1;
            held_key[slot]   = key;
            held_data[slot]  = value;
            held_rank[slot]  = 0;
            held_fill++;
        end
    endtask

    // Offer one item after a random gap; predict at the accepting edge.
    // Valid stays high into the next item when the next gap is zero.
    task automatic send_item(input logic op, input logic [31:0] key,
                             input logic [31:0] value, input logic typed,
                             input t_result typed_result);
        int      gap;
        t_result res;
        gap = idle_enable ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.key       <= key;
        req_if.value     <= value;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        predict_access(op, key, value, res);
        expected_results.push_back(typed ? typed_result : res);
    endtask

    // Drop valid and hold until every response is back, then let the pipeline settle.
    task automatic wait_for_idle();
        req_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [lkv_pkg::CAP_W-1:0] cap);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        held_capacity = cap;
        cfg_we <= 1'b0;
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] %s mismatch: expected %h, got %h", $realtime, what, want, got);
    endtask

    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            note_mismatch("unexpected response, read_value", 32'h0, rsp_if.read_value);
            return;
        end
        want = expected_results.pop_front();
        if (rsp_if.hit !== want.hit)
            note_mismatch("hit", 32'(want.hit), 32'(rsp_if.hit));
        if (rsp_if.read_value !== want.read_value)
            note_mismatch("read_value", want.read_value, rsp_if.read_value);
        if (rsp_if.evicted !== want.evicted)
            note_mismatch("evicted", 32'(want.evicted), 32'(rsp_if.evicted));
        if (rsp_if.evicted_key !== want.evicted_key)
            note_mismatch("evicted_key", want.evicted_key, rsp_if.evicted_key);
    endtask

    // ------------------------------------------------------------------------
    // Response side: stall a random number of cycles before each item, and
    // once hold ready low for a long stretch so the cache backs up.
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (rx_hold_request) begin
                rsp_if.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold_request = 1'b0;
            end
            gap = idle_enable ? $urandom_range(0, MAX_IDLE) : 0;
            if (gap > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (rsp_if.valid !== 1'b1);
            check_result();
        end
    end

    // Watchdog: a hung handshake or a lost response ends the run here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Request side and phase sequencing.
    // ------------------------------------------------------------------------
    initial begin
        t_result     no_result;
        logic [31:0] key_pool [$];
        int          pool_size;
        logic        op;
        logic [31:0] key;

        no_result = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            held_valid[i] = 1'b0;
            held_key[i]   = '0;
            held_data[i]  = '0;
            held_rank[i]  = 0;
        end
        held_fill     = 0;
        held_capacity = lkv_pkg::CAP_RESET;

        req_if.valid     <= 1'b0;
        req_if.operation <= lkv_pkg::OP_GET;
        req_if.key       <= '0;
        req_if.value     <= '0;
        rst_n            <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; register rows wait for the cache to go idle
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (directed_rows[r].kind == ROW_CAPACITY) begin
                wait_for_idle();
                write_capacity(directed_rows[r].value[lkv_pkg::CAP_W-1:0]);
            end else begin
                send_item(directed_rows[r].operation, directed_rows[r].key,
                          directed_rows[r].value, directed_rows[r].typed,
                          directed_rows[r].expected);
            end
        end

        // Random phases. Keys come mostly from a pool of one to capacity plus four
        // keys, so hits, updates and evictions all happen; a tenth are fresh random
        // keys across the full range.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            wait_for_idle();
            write_capacity(PHASE_CAPACITY[p]);
            // two phases run back to back with no gaps on either side
            idle_enable = (p != 3 && p != 7);
            key_pool.delete();
            pool_size = $urandom_range(1, capacity_limit(PHASE_CAPACITY[p]) + 4);
            for (int k = 0; k < pool_size; k++) key_pool.push_back($urandom);
            if (p == LONG_HOLD_PHASE) rx_hold_request = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // pause the sender until every response is home
                if (p == DRAIN_PHASE && n == PHASE_ITEMS / 2) wait_for_idle();
                if ($urandom_range(0, 19) == 0)
                    key_pool[$urandom_range(0, pool_size - 1)] = $urandom;
                op  = 1'($urandom_range(0, 1));
                key = ($urandom_range(0, 9) == 0) ? $urandom
                                                  : key_pool[$urandom_range(0, pool_size - 1)];
                send_item(op, key, $urandom, 1'b0, no_result);
            end
        end

        wait_for_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
